// File: rtl/tfrt_pkg.sv
// shared types, codes and default sizes of the tcp flow rtt tracker
package tfrt_pkg;

  localparam int SEQ_DEPTH_DEF = 64;
  localparam int REP_DEPTH_DEF = 64;

  localparam logic [2:0] STAT_IGNORED = 3'd0;
  localparam logic [2:0] STAT_SENT    = 3'd1;
  localparam logic [2:0] STAT_HELD    = 3'd2;
  localparam logic [2:0] STAT_MATCH   = 3'd3;
  localparam logic [2:0] STAT_NOMATCH = 3'd4;
  localparam logic [2:0] STAT_FULL    = 3'd5;

  typedef struct packed {
    logic        action;
    logic        ack_flag;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] seq_or_ack;
    logic [63:0] now_ns;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] rtt_ns;
    logic [31:0] avg_rtt_ns;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEQ_SCAN,
    ST_REP_SCAN,
    ST_DONE
  } state_t;

endpackage

// File: rtl/tfrt_seq_cell.sv
// one sequence table entry with its recency rank and its stage of the lookup token
module tfrt_seq_cell #(
  parameter int DEPTH = tfrt_pkg::SEQ_DEPTH_DEF,
  parameter int IDX = 0,
  localparam int SW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [63:0]   key_addrs,
  input  logic [31:0]   key_ports,
  input  logic [31:0]   key_num,
  input  logic [31:0]   wr_time,
  input  logic          ti_vld,
  input  logic          ti_hit,
  input  logic [SW-1:0] ti_hidx,
  input  logic [SW-1:0] ti_hrank,
  input  logic [31:0]   ti_htime,
  input  logic          ti_free,
  input  logic [SW-1:0] ti_fidx,
  input  logic [SW-1:0] ti_frank,
  input  logic [SW-1:0] ti_vidx,
  output logic          to_vld,
  output logic          to_hit,
  output logic [SW-1:0] to_hidx,
  output logic [SW-1:0] to_hrank,
  output logic [31:0]   to_htime,
  output logic          to_free,
  output logic [SW-1:0] to_fidx,
  output logic [SW-1:0] to_frank,
  output logic [SW-1:0] to_vidx,
  input  logic          upd_wr,
  input  logic          upd_touch,
  input  logic [SW-1:0] upd_idx,
  input  logic [SW-1:0] upd_rank
);

  localparam logic [SW-1:0] MY_IDX = SW'(IDX);
  localparam logic [SW-1:0] OLDEST = SW'(DEPTH - 1);

  logic          valid_r;
  logic [SW-1:0] rank_r;
  logic [63:0]   addrs_r;
  logic [31:0]   ports_r;
  logic [31:0]   num_r;
  logic [31:0]   time_r;
  logic          match;
  logic          sel;

  assign match = valid_r && addrs_r == key_addrs && ports_r == key_ports && num_r == key_num;
  assign sel = upd_idx == MY_IDX;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rank_r  <= MY_IDX;
      to_vld  <= 1'b0;
    end else begin
      to_vld <= ti_vld;
      if (upd_wr && sel) begin
        valid_r <= 1'b1;
      end
      if (upd_touch) begin
        if (sel) begin
          rank_r <= '0;
        end else if (rank_r < upd_rank) begin
          rank_r <= rank_r + SW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd_wr && sel) begin
      addrs_r <= key_addrs;
      ports_r <= key_ports;
      num_r   <= key_num;
      time_r  <= wr_time;
    end
    to_hit   <= ti_hit | match;
    to_hidx  <= ti_hit ? ti_hidx : MY_IDX;
    to_hrank <= ti_hit ? ti_hrank : rank_r;
    to_htime <= ti_hit ? ti_htime : time_r;
    to_free  <= ti_free | !valid_r;
    to_fidx  <= ti_free ? ti_fidx : MY_IDX;
    to_frank <= ti_free ? ti_frank : rank_r;
    to_vidx  <= (rank_r == OLDEST) ? MY_IDX : ti_vidx;
  end

endmodule

// File: rtl/tfrt_rep_cell.sv
// one report table entry with its stage of the flow lookup token
module tfrt_rep_cell #(
  parameter int DEPTH = tfrt_pkg::REP_DEPTH_DEF,
  parameter int IDX = 0,
  localparam int RW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [63:0]   key_addrs,
  input  logic [31:0]   key_ports,
  input  logic          ti_vld,
  input  logic          ti_hit,
  input  logic [RW-1:0] ti_hidx,
  input  logic [31:0]   ti_havg,
  input  logic          ti_free,
  input  logic [RW-1:0] ti_fidx,
  output logic          to_vld,
  output logic          to_hit,
  output logic [RW-1:0] to_hidx,
  output logic [31:0]   to_havg,
  output logic          to_free,
  output logic [RW-1:0] to_fidx,
  input  logic          upd_wr,
  input  logic          upd_new,
  input  logic [RW-1:0] upd_idx,
  input  logic [31:0]   upd_avg
);

  localparam logic [RW-1:0] MY_IDX = RW'(IDX);

  logic        valid_r;
  logic [63:0] addrs_r;
  logic [31:0] ports_r;
  logic [31:0] avg_r;
  logic        match;
  logic        sel;

  assign match = valid_r && addrs_r == key_addrs && ports_r == key_ports;
  assign sel = upd_wr && upd_idx == MY_IDX;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      to_vld  <= 1'b0;
    end else begin
      to_vld <= ti_vld;
      if (sel && upd_new) begin
        valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sel) begin
      avg_r <= upd_avg;
      if (upd_new) begin
        addrs_r <= key_addrs;
        ports_r <= key_ports;
      end
    end
    to_hit  <= ti_hit | match;
    to_hidx <= ti_hit ? ti_hidx : MY_IDX;
    to_havg <= ti_hit ? ti_havg : avg_r;
    to_free <= ti_free | !valid_r;
    to_fidx <= ti_free ? ti_fidx : MY_IDX;
  end

endmodule

// File: rtl/tcp_flow_rtt_tracker_core.sv
// top level of the tcp flow rtt tracker: controller and the two cell chains
// Each transaction gives exactly one result. A lookup token walks the sequence
// table cells one per cycle. An ignored packet skips the scans, and an ack that
// matches walks the report table cells too. One packet is processed at a time;
// the next one is taken while the previous result still sits in the output
// register.
module tcp_flow_rtt_tracker_core #(
  parameter int SEQ_TABLE_DEPTH = tfrt_pkg::SEQ_DEPTH_DEF,
  parameter int REPORT_TABLE_DEPTH = tfrt_pkg::REP_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tfrt_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tfrt_pkg::out_item_t out_data
);

  localparam int SW = $clog2(SEQ_TABLE_DEPTH);
  localparam int RW = (REPORT_TABLE_DEPTH > 1) ? $clog2(REPORT_TABLE_DEPTH) : 1;
  localparam int NS = SEQ_TABLE_DEPTH;
  localparam int NR = REPORT_TABLE_DEPTH;

  tfrt_pkg::state_t state_r, state_nxt;

  logic [63:0] key_addrs_r;
  logic [31:0] key_ports_r;
  logic [31:0] key_num_r;
  logic [31:0] now_r;
  logic        act_r;
  logic        seq_go_r, seq_go_nxt;
  logic        rep_go_r, rep_go_nxt;
  logic [2:0]  status_r, status_nxt;
  logic [31:0] rtt_r, rtt_nxt;
  logic [31:0] avg_r, avg_nxt;
  logic        out_valid_r;
  tfrt_pkg::out_item_t out_data_r;
  logic        out_load;

  logic          seq_wr, seq_touch;
  logic [SW-1:0] seq_idx, seq_rank;
  logic          rep_wr, rep_new;
  logic [RW-1:0] rep_idx;
  logic [31:0]   rep_avg;
  logic [32:0]   avg_sum;

  logic          s_vld   [0:NS];
  logic          s_hit   [0:NS];
  logic [SW-1:0] s_hidx  [0:NS];
  logic [SW-1:0] s_hrank [0:NS];
  logic [31:0]   s_htime [0:NS];
  logic          s_free  [0:NS];
  logic [SW-1:0] s_fidx  [0:NS];
  logic [SW-1:0] s_frank [0:NS];
  logic [SW-1:0] s_vidx  [0:NS];

  logic          r_vld  [0:NR];
  logic          r_hit  [0:NR];
  logic [RW-1:0] r_hidx [0:NR];
  logic [31:0]   r_havg [0:NR];
  logic          r_free [0:NR];
  logic [RW-1:0] r_fidx [0:NR];

  assign s_vld[0]   = seq_go_r;
  assign s_hit[0]   = 1'b0;
  assign s_hidx[0]  = '0;
  assign s_hrank[0] = '0;
  assign s_htime[0] = '0;
  assign s_free[0]  = 1'b0;
  assign s_fidx[0]  = '0;
  assign s_frank[0] = '0;
  assign s_vidx[0]  = '0;

  assign r_vld[0]  = rep_go_r;
  assign r_hit[0]  = 1'b0;
  assign r_hidx[0] = '0;
  assign r_havg[0] = '0;
  assign r_free[0] = 1'b0;
  assign r_fidx[0] = '0;

  for (genvar i = 0; i < NS; i++) begin : g_seq
    tfrt_seq_cell #(.DEPTH(NS), .IDX(i)) u_cell (
      .clk(clk), .rst_n(rst_n),
      .key_addrs(key_addrs_r), .key_ports(key_ports_r), .key_num(key_num_r),
      .wr_time(now_r),
      .ti_vld(s_vld[i]), .ti_hit(s_hit[i]), .ti_hidx(s_hidx[i]),
      .ti_hrank(s_hrank[i]), .ti_htime(s_htime[i]), .ti_free(s_free[i]),
      .ti_fidx(s_fidx[i]), .ti_frank(s_frank[i]), .ti_vidx(s_vidx[i]),
      .to_vld(s_vld[i+1]), .to_hit(s_hit[i+1]), .to_hidx(s_hidx[i+1]),
      .to_hrank(s_hrank[i+1]), .to_htime(s_htime[i+1]), .to_free(s_free[i+1]),
      .to_fidx(s_fidx[i+1]), .to_frank(s_frank[i+1]), .to_vidx(s_vidx[i+1]),
      .upd_wr(seq_wr), .upd_touch(seq_touch), .upd_idx(seq_idx), .upd_rank(seq_rank)
    );
  end

  for (genvar j = 0; j < NR; j++) begin : g_rep
    tfrt_rep_cell #(.DEPTH(NR), .IDX(j)) u_cell (
      .clk(clk), .rst_n(rst_n),
      .key_addrs(key_addrs_r), .key_ports(key_ports_r),
      .ti_vld(r_vld[j]), .ti_hit(r_hit[j]), .ti_hidx(r_hidx[j]),
      .ti_havg(r_havg[j]), .ti_free(r_free[j]), .ti_fidx(r_fidx[j]),
      .to_vld(r_vld[j+1]), .to_hit(r_hit[j+1]), .to_hidx(r_hidx[j+1]),
      .to_havg(r_havg[j+1]), .to_free(r_free[j+1]), .to_fidx(r_fidx[j+1]),
      .upd_wr(rep_wr), .upd_new(rep_new), .upd_idx(rep_idx), .upd_avg(rep_avg)
    );
  end

  assign in_stall = state_r != tfrt_pkg::ST_IDLE;
  assign out_load = !out_valid_r || !out_stall;
  assign avg_sum  = {1'b0, rtt_r} + {1'b0, r_havg[NR]};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tfrt_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (!in_data.action || in_data.ack_flag) ?
                      tfrt_pkg::ST_SEQ_SCAN : tfrt_pkg::ST_DONE;
        end
      end
      tfrt_pkg::ST_SEQ_SCAN: begin
        if (s_vld[NS]) begin
          state_nxt = (act_r && s_hit[NS]) ? tfrt_pkg::ST_REP_SCAN : tfrt_pkg::ST_DONE;
        end
      end
      tfrt_pkg::ST_REP_SCAN: begin
        if (r_vld[NR]) begin
          state_nxt = tfrt_pkg::ST_DONE;
        end
      end
      tfrt_pkg::ST_DONE: begin
        if (out_load) begin
          state_nxt = tfrt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tfrt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    seq_go_nxt = 1'b0;
    rep_go_nxt = 1'b0;
    seq_wr     = 1'b0;
    seq_touch  = 1'b0;
    seq_idx    = '0;
    seq_rank   = '0;
    rep_wr     = 1'b0;
    rep_new    = 1'b0;
    rep_idx    = '0;
    rep_avg    = '0;
    status_nxt = status_r;
    rtt_nxt    = rtt_r;
    avg_nxt    = avg_r;
    case (state_r)
      tfrt_pkg::ST_IDLE: begin
        if (in_valid) begin
          status_nxt = tfrt_pkg::STAT_IGNORED;
          rtt_nxt    = '0;
          avg_nxt    = '0;
          seq_go_nxt = !in_data.action || in_data.ack_flag;
        end
      end
      tfrt_pkg::ST_SEQ_SCAN: begin
        if (s_vld[NS]) begin
          if (s_hit[NS]) begin
            seq_touch = 1'b1;
            seq_idx   = s_hidx[NS];
            seq_rank  = s_hrank[NS];
            if (act_r) begin
              rtt_nxt    = now_r - s_htime[NS];
              rep_go_nxt = 1'b1;
            end else begin
              status_nxt = tfrt_pkg::STAT_HELD;
            end
          end else if (!act_r) begin
            seq_wr     = 1'b1;
            seq_touch  = 1'b1;
            seq_idx    = s_free[NS] ? s_fidx[NS] : s_vidx[NS];
            seq_rank   = s_free[NS] ? s_frank[NS] : SW'(NS - 1);
            status_nxt = tfrt_pkg::STAT_SENT;
          end else begin
            status_nxt = tfrt_pkg::STAT_NOMATCH;
          end
        end
      end
      tfrt_pkg::ST_REP_SCAN: begin
        if (r_vld[NR]) begin
          if (r_hit[NR]) begin
            rep_wr     = 1'b1;
            rep_idx    = r_hidx[NR];
            rep_avg    = avg_sum[32:1];
            avg_nxt    = avg_sum[32:1];
            status_nxt = tfrt_pkg::STAT_MATCH;
          end else if (r_free[NR]) begin
            rep_wr     = 1'b1;
            rep_new    = 1'b1;
            rep_idx    = r_fidx[NR];
            rep_avg    = rtt_r;
            avg_nxt    = rtt_r;
            status_nxt = tfrt_pkg::STAT_MATCH;
          end else begin
            status_nxt = tfrt_pkg::STAT_FULL;
          end
        end
      end
      tfrt_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tfrt_pkg::ST_IDLE;
      seq_go_r    <= 1'b0;
      rep_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      seq_go_r <= seq_go_nxt;
      rep_go_r <= rep_go_nxt;
      if (state_r == tfrt_pkg::ST_DONE && out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    rtt_r    <= rtt_nxt;
    avg_r    <= avg_nxt;
    if (state_r == tfrt_pkg::ST_IDLE && in_valid) begin
      act_r     <= in_data.action;
      key_num_r <= in_data.seq_or_ack;
      now_r     <= in_data.now_ns[31:0];
      if (in_data.action) begin
        key_addrs_r <= {in_data.dst_addr, in_data.src_addr};
        key_ports_r <= {in_data.dst_port, in_data.src_port};
      end else begin
        key_addrs_r <= {in_data.src_addr, in_data.dst_addr};
        key_ports_r <= {in_data.src_port, in_data.dst_port};
      end
    end
    if (state_r == tfrt_pkg::ST_DONE && out_load) begin
      out_data_r.status     <= status_r;
      out_data_r.rtt_ns     <= rtt_r;
      out_data_r.avg_rtt_ns <= avg_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_seq_end_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    s_vld[NS] |-> state_r == tfrt_pkg::ST_SEQ_SCAN)
    else $error("sequence token left the chain outside its scan");
  a_rep_end_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    r_vld[NR] |-> state_r == tfrt_pkg::ST_REP_SCAN)
    else $error("report token left the chain outside its scan");
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == tfrt_pkg::ST_DONE))
    else $error("result shown without a finished transaction");
`endif

endmodule

// File: verif/tcp_flow_rtt_tracker_core_checker.sv
// checker for the tcp flow rtt tracker: predicts each result and compares it
`timescale 1ns / 1ps
module tcp_flow_rtt_tracker_core_checker #(
  parameter int SEQ_TABLE_DEPTH = tfrt_pkg::SEQ_DEPTH_DEF,
  parameter int REPORT_TABLE_DEPTH = tfrt_pkg::REP_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  tfrt_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  tfrt_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  pending_count
);

  logic        sq_valid [SEQ_TABLE_DEPTH];
  logic [63:0] sq_addrs [SEQ_TABLE_DEPTH];
  logic [31:0] sq_ports [SEQ_TABLE_DEPTH];
  logic [31:0] sq_num   [SEQ_TABLE_DEPTH];
  logic [63:0] sq_sent  [SEQ_TABLE_DEPTH];
  int          sq_rank  [SEQ_TABLE_DEPTH];
  logic        rp_valid [REPORT_TABLE_DEPTH];
  logic [63:0] rp_addrs [REPORT_TABLE_DEPTH];
  logic [31:0] rp_ports [REPORT_TABLE_DEPTH];
  logic [31:0] rp_avg   [REPORT_TABLE_DEPTH];

  tfrt_pkg::out_item_t expected_results [$];

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic void clear_tables();
    for (int i = 0; i < SEQ_TABLE_DEPTH; i++) begin
      sq_valid[i] = 1'b0;
      sq_rank[i] = i;
    end
    for (int i = 0; i < REPORT_TABLE_DEPTH; i++) rp_valid[i] = 1'b0;
  endfunction

  function automatic void make_newest(int e);
    int r;
    r = sq_rank[e];
    for (int i = 0; i < SEQ_TABLE_DEPTH; i++) if (sq_rank[i] < r) sq_rank[i]++;
    sq_rank[e] = 0;
  endfunction

  function automatic int lookup_send(logic [63:0] a, logic [31:0] p, logic [31:0] n);
    for (int i = 0; i < SEQ_TABLE_DEPTH; i++)
      if (sq_valid[i] && sq_addrs[i] == a && sq_ports[i] == p && sq_num[i] == n)
        return i;
    return -1;
  endfunction

  function automatic tfrt_pkg::out_item_t track_packet(tfrt_pkg::in_item_t pkt);
    tfrt_pkg::out_item_t res;
    logic [63:0] a;
    logic [31:0] p;
    logic [32:0] sum;
    int e, r, fr;
    res = '0;
    res.status = tfrt_pkg::STAT_IGNORED;
    if (pkt.action == 1'b0) begin
      a = {pkt.src_addr, pkt.dst_addr};
      p = {pkt.src_port, pkt.dst_port};
      e = lookup_send(a, p, pkt.seq_or_ack);
      if (e >= 0) begin
        res.status = tfrt_pkg::STAT_HELD;
      end else begin
        e = -1;
        for (int i = 0; i < SEQ_TABLE_DEPTH; i++)
          if (e < 0 && !sq_valid[i]) e = i;
        if (e < 0) begin
          e = 0;
          for (int i = 1; i < SEQ_TABLE_DEPTH; i++) if (sq_rank[i] > sq_rank[e]) e = i;
        end
        sq_valid[e] = 1'b1;
        sq_addrs[e] = a;
        sq_ports[e] = p;
        sq_num[e] = pkt.seq_or_ack;
        sq_sent[e] = pkt.now_ns;
        res.status = tfrt_pkg::STAT_SENT;
      end
      make_newest(e);
    end else if (pkt.ack_flag) begin
      a = {pkt.dst_addr, pkt.src_addr};
      p = {pkt.dst_port, pkt.src_port};
      e = lookup_send(a, p, pkt.seq_or_ack);
      if (e < 0) begin
        res.status = tfrt_pkg::STAT_NOMATCH;
      end else begin
        make_newest(e);
        res.rtt_ns = 32'(pkt.now_ns - sq_sent[e]);
        r = -1;
        fr = -1;
        for (int i = 0; i < REPORT_TABLE_DEPTH; i++) begin
          if (rp_valid[i]) begin
            if (r < 0 && rp_addrs[i] == a && rp_ports[i] == p) r = i;
          end else if (fr < 0) begin
            fr = i;
          end
        end
        if (r >= 0) begin
          sum = {1'b0, res.rtt_ns} + {1'b0, rp_avg[r]};
          rp_avg[r] = sum[32:1];
          res.avg_rtt_ns = rp_avg[r];
          res.status = tfrt_pkg::STAT_MATCH;
        end else if (fr >= 0) begin
          rp_valid[fr] = 1'b1;
          rp_addrs[fr] = a;
          rp_ports[fr] = p;
          rp_avg[fr] = res.rtt_ns;
          res.avg_rtt_ns = res.rtt_ns;
          res.status = tfrt_pkg::STAT_MATCH;
        end else begin
          res.status = tfrt_pkg::STAT_FULL;
        end
      end
    end
    return res;
  endfunction

  initial begin
    fail_count = 0;
    clear_tables();
  end

  assign pending_count = expected_results.size();

  always @(posedge clk) begin
    tfrt_pkg::out_item_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) expected_results.push_back(track_packet(in_data));
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected transaction", 64'(out_data.status), 64'd0);
        end else begin
          want = expected_results.pop_front();
          if (out_data.status !== want.status)
            report_mismatch("status", 64'(out_data.status), 64'(want.status));
          if (out_data.rtt_ns !== want.rtt_ns)
            report_mismatch("rtt_ns", 64'(out_data.rtt_ns), 64'(want.rtt_ns));
          if (out_data.avg_rtt_ns !== want.avg_rtt_ns)
            report_mismatch("avg_rtt_ns", 64'(out_data.avg_rtt_ns), 64'(want.avg_rtt_ns));
        end
      end
    end
  end
endmodule

// File: verif/tcp_flow_rtt_tracker_core_test.sv
// testbench top for the tcp flow rtt tracker: stimulus, stalls and verdict
`timescale 1ns / 1ps
module tcp_flow_rtt_tracker_core_test;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  tfrt_pkg::in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  tfrt_pkg::out_item_t out_data;
  int        fail_count;
  int        pending_count;
  int        cycle_count;
  bit        hold_off;
  bit        stim_done;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int HOLD_CYCLES = 600;
  localparam int IN_W = $bits(tfrt_pkg::in_item_t);

  // small pools of flows so sends and acks meet and tables fill
  logic [31:0] pool_addr [8];
  logic [15:0] pool_port [8];
  logic [31:0] pool_seq  [8];
  logic [63:0] clock_ns;

  tcp_flow_rtt_tracker_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  tcp_flow_rtt_tracker_core_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int d;
    d = $urandom_range(0, 99);
    if (d < 50) return 0;
    if (d < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 200);
  endfunction

  task automatic send_packet(input tfrt_pkg::in_item_t pkt);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= pkt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic tfrt_pkg::in_item_t make_packet(bit dir, bit ackf, int f,
                                                     logic [31:0] num, logic [63:0] t);
    tfrt_pkg::in_item_t pkt;
    pkt.action = dir;
    pkt.ack_flag = ackf;
    if (!dir) begin
      pkt.src_addr = pool_addr[f];
      pkt.dst_addr = pool_addr[(f + 1) % 8];
      pkt.src_port = pool_port[f];
      pkt.dst_port = pool_port[(f + 1) % 8];
    end else begin
      pkt.src_addr = pool_addr[(f + 1) % 8];
      pkt.dst_addr = pool_addr[f];
      pkt.src_port = pool_port[(f + 1) % 8];
      pkt.dst_port = pool_port[f];
    end
    pkt.seq_or_ack = num;
    pkt.now_ns = t;
    return pkt;
  endfunction

  function automatic tfrt_pkg::in_item_t random_packet();
    tfrt_pkg::in_item_t pkt;
    int d;
    int f;
    d = $urandom_range(0, 99);
    f = $urandom_range(0, 7);
    clock_ns = clock_ns + $urandom_range(0, 100000);
    if (d < 10) begin
      pkt = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    end else if (d < 50) begin
      pkt = make_packet(1'b0, 1'($urandom), f, pool_seq[f] + $urandom_range(0, 15), clock_ns);
    end else if (d < 90) begin
      pkt = make_packet(1'b1, 1'b1, f, pool_seq[f] + $urandom_range(0, 17), clock_ns);
    end else if (d < 95) begin
      pkt = make_packet(1'b1, 1'b0, f, pool_seq[f] + $urandom_range(0, 15), clock_ns);
    end else begin
      pkt = make_packet(1'b1, 1'b1, f, pool_seq[f], {$urandom, $urandom});
    end
    return pkt;
  endfunction

  initial begin
    int held;
    out_stall = 1'b0;
    @(posedge rst_n);
    while (!stim_done) begin
      @(posedge clk);
      if (hold_off) begin
        // long hold-off while the sender keeps offering
        out_stall <= 1'b1;
        held = 0;
        while (held < HOLD_CYCLES) begin
          @(posedge clk);
          held++;
        end
        hold_off = 1'b0;
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat (1 + pick_gap()) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
    @(posedge clk);
    out_stall <= 1'b0;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("tcp_flow_rtt_tracker_core regression: fail");
        $finish;
      end
    end
  end

  initial begin
    tfrt_pkg::in_item_t pkt;
    int waited;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    hold_off = 1'b0;
    stim_done = 1'b0;
    clock_ns = 64'd1000;
    for (int i = 0; i < 8; i++) begin
      pool_addr[i] = $urandom;
      pool_port[i] = 16'($urandom);
      pool_seq[i] = $urandom;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes, every status but full, time going backwards, repeated acks
    send_packet('{action: 1'b0, ack_flag: 1'b1, src_addr: '1, dst_addr: '1, src_port: '1,
                  dst_port: '1, seq_or_ack: '1, now_ns: '1});
    send_packet('{action: 1'b0, ack_flag: 1'b0, src_addr: '1, dst_addr: '1, src_port: '1,
                  dst_port: '1, seq_or_ack: '1, now_ns: '0});
    send_packet('{action: 1'b1, ack_flag: 1'b1, src_addr: '1, dst_addr: '1, src_port: '1,
                  dst_port: '1, seq_or_ack: '1, now_ns: 64'h0000_0001_0000_0005});
    send_packet('{action: 1'b1, ack_flag: 1'b1, src_addr: '1, dst_addr: '1, src_port: '1,
                  dst_port: '1, seq_or_ack: '1, now_ns: 64'hFFFF_FFFF_0000_0000});
    send_packet('{action: 1'b0, ack_flag: 1'b0, src_addr: '0, dst_addr: '0, src_port: '0,
                  dst_port: '0, seq_or_ack: '0, now_ns: 64'd500});
    send_packet('{action: 1'b1, ack_flag: 1'b0, src_addr: '0, dst_addr: '0, src_port: '0,
                  dst_port: '0, seq_or_ack: '0, now_ns: 64'd900});
    send_packet('{action: 1'b1, ack_flag: 1'b1, src_addr: '0, dst_addr: '0, src_port: '0,
                  dst_port: '0, seq_or_ack: '0, now_ns: 64'd100});
    send_packet('{action: 1'b1, ack_flag: 1'b1, src_addr: '0, dst_addr: '0, src_port: '0,
                  dst_port: '0, seq_or_ack: 32'd1, now_ns: 64'd100});
    for (int k = 0; k < 4; k++) begin
      send_packet(make_packet(1'b0, 1'b0, k, pool_seq[k], clock_ns));
      clock_ns += 64'd12345;
      send_packet(make_packet(1'b1, 1'b1, k, pool_seq[k], clock_ns));
    end

    // overflow the report table and the send table with 70 distinct flows
    for (int k = 0; k < 70; k++) begin
      pkt = '{action: 1'b0, ack_flag: 1'b0, src_addr: 32'hC0A8_0000 + k,
              dst_addr: 32'h0A00_0001, src_port: 16'(k), dst_port: 16'd80,
              seq_or_ack: 32'(k * 7), now_ns: clock_ns};
      send_packet(pkt);
      clock_ns += $urandom_range(1, 5000);
      pkt.action = 1'b1;
      pkt.ack_flag = 1'b1;
      pkt.src_addr = 32'h0A00_0001;
      pkt.dst_addr = 32'hC0A8_0000 + k;
      pkt.src_port = 16'd80;
      pkt.dst_port = 16'(k);
      pkt.now_ns = clock_ns;
      send_packet(pkt);
    end

    for (int n = 0; n < 1300; n++) begin
      if (n == 400) hold_off = 1'b1;
      send_packet(random_packet());
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;

    waited = 0;
    while (pending_count != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("tcp_flow_rtt_tracker_core regression: pass");
    end else begin
      $display("tcp_flow_rtt_tracker_core regression: fail");
    end
    $finish;
  end
endmodule

// File: filelist.f
rtl/tfrt_pkg.sv
rtl/tfrt_seq_cell.sv
rtl/tfrt_rep_cell.sv
rtl/tcp_flow_rtt_tracker_core.sv
verif/tcp_flow_rtt_tracker_core_checker.sv
verif/tcp_flow_rtt_tracker_core_test.sv
